// ===== rtl/ipl4c_pkg.sv =====
package ipl4c_pkg;

  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [3:0]  IP_VERSION_4  = 4'd4;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;
  localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
  localparam logic [5:0]  UDP_HDR_BYTES = 6'd8;
  localparam logic [2:0]  SIG_LEN       = 3'd4;

  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_HTTPS    = 16'd443;
  localparam logic [15:0] PORT_FTP_CTRL = 16'd21;
  localparam logic [15:0] PORT_FTP_DATA = 16'd20;
  localparam logic [15:0] PORT_SMTP     = 16'd25;
  localparam logic [15:0] PORT_DNS      = 16'd53;
  localparam logic [15:0] PORT_SSH      = 16'd22;

  typedef enum logic [3:0] {
    SVC_HTTP     = 4'd0,
    SVC_HTTPS    = 4'd1,
    SVC_FTP_CTRL = 4'd2,
    SVC_FTP_DATA = 4'd3,
    SVC_SMTP     = 4'd4,
    SVC_DNS      = 4'd5,
    SVC_SSH      = 4'd6,
    SVC_UNKNOWN  = 4'd7,
    SVC_NONE     = 4'd8
  } svc_e;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_addr;
    logic [7:0]  ip_proto;
    logic        l4_ok;
    logic        has_ports;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
    logic        sig_hit;
    logic        truncated;
  } pkt_sum_t;

  function automatic logic [7:0] http_sig_byte(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = 8'h48;
      2'd1:    b = 8'h54;
      2'd2:    b = 8'h54;
      default: b = 8'h50;
    endcase
    return b;
  endfunction

  function automatic logic [5:0] hdr_bytes(input logic [3:0] words);
    return (words < MIN_HDR_WORDS) ? MIN_HDR_BYTES : {words, 2'b00};
  endfunction

  function automatic logic [5:0] l4_bytes(input logic [7:0] proto, input logic [3:0] words);
    logic [5:0] n;
    n = '0;
    if (proto == PROTO_TCP) begin
      n = hdr_bytes(words);
    end else if (proto == PROTO_UDP) begin
      n = UDP_HDR_BYTES;
    end
    return n;
  endfunction

  function automatic logic port_is(input logic [15:0] sp, input logic [15:0] dp,
                                   input logic [15:0] p);
    return (sp == p) || (dp == p);
  endfunction

  function automatic svc_e classify(input logic l4_ok, input logic [15:0] sp,
                                    input logic [15:0] dp, input logic sig_hit);
    svc_e s;
    if (!l4_ok) begin
      s = SVC_NONE;
    end else if (port_is(sp, dp, PORT_HTTP) || sig_hit) begin
      s = SVC_HTTP;
    end else if (port_is(sp, dp, PORT_HTTPS)) begin
      s = SVC_HTTPS;
    end else if (port_is(sp, dp, PORT_FTP_CTRL)) begin
      s = SVC_FTP_CTRL;
    end else if (port_is(sp, dp, PORT_FTP_DATA)) begin
      s = SVC_FTP_DATA;
    end else if (port_is(sp, dp, PORT_SMTP)) begin
      s = SVC_SMTP;
    end else if (port_is(sp, dp, PORT_DNS)) begin
      s = SVC_DNS;
    end else if (port_is(sp, dp, PORT_SSH)) begin
      s = SVC_SSH;
    end else begin
      s = SVC_UNKNOWN;
    end
    return s;
  endfunction

endpackage

// ===== rtl/ipl4c_in_if.sv =====
interface ipl4c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/ipl4c_out_if.sv =====
interface ipl4c_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_ip;
  logic [31:0] dst_addr;
  logic [7:0]  ip_proto;
  logic        has_ports;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] payload_len;
  logic [3:0]  service;
  logic        truncated;

  modport source (output valid, output src_ip, output dst_addr, output ip_proto,
                  output has_ports, output src_port, output dst_port,
                  output payload_len, output service, output truncated, input ready);
  modport sink   (input valid, input src_ip, input dst_addr, input ip_proto,
                  input has_ports, input src_port, input dst_port,
                  input payload_len, input service, input truncated, output ready);
endinterface

// ===== rtl/ipl4c_parser.sv =====
module ipl4c_parser
  import ipl4c_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       emit_o,
  output pkt_sum_t   sum_o
);

  localparam int unsigned IdxW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(MAX_PACKET_BYTES);

  logic [IdxW-1:0] idx_q;
  logic [3:0]      ver_q, ver_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [7:0]      proto_q, proto_d;
  logic [31:0]     src_q, src_d;
  logic [31:0]     dst_q, dst_d;
  logic [15:0]     sport_q, sport_d;
  logic [15:0]     dport_q, dport_d;
  logic [3:0]      tw_q, tw_d;
  logic [2:0]      sig_q, sig_d;

  logic            in_range;
  logic            l4_cur;
  logic            in_sig;
  logic [1:0]      k;
  logic [IdxW-1:0] h, h1, h2, h3, h12, p, p4;
  logic [IdxW-1:0] len, hr, hl, hr4;
  logic            l4_ok;

  always_comb begin
    ver_d   = ver_q;
    ihl_d   = ihl_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    sport_d = sport_q;
    dport_d = dport_q;
    tw_d    = tw_q;
    sig_d   = sig_q;

    in_range = idx_q < IdxMax;
    l4_cur   = (proto_q == PROTO_TCP) || (proto_q == PROTO_UDP);
    h        = IdxW'(hdr_bytes(ihl_q));
    h1       = h + IdxW'(1);
    h2       = h + IdxW'(2);
    h3       = h + IdxW'(3);
    h12      = h + IdxW'(12);
    p        = h + IdxW'(l4_bytes(proto_q, tw_q));
    p4       = p + IdxW'(SIG_LEN);
    in_sig   = (idx_q >= p) && (idx_q < p4);
    k        = 2'(idx_q - p);

    if (in_range) begin
      if (idx_q == '0) begin
        ver_d = data_byte_i[7:4];
        ihl_d = data_byte_i[3:0];
      end else begin
        if (idx_q == IdxW'(9)) begin
          proto_d = data_byte_i;
        end
        if ((idx_q >= IdxW'(12)) && (idx_q < IdxW'(16))) begin
          src_d = {src_q[23:0], data_byte_i};
        end
        if ((idx_q >= IdxW'(16)) && (idx_q < IdxW'(20))) begin
          dst_d = {dst_q[23:0], data_byte_i};
        end
        if (l4_cur) begin
          if ((idx_q == h) || (idx_q == h1)) begin
            sport_d = {sport_q[7:0], data_byte_i};
          end
          if ((idx_q == h2) || (idx_q == h3)) begin
            dport_d = {dport_q[7:0], data_byte_i};
          end
          if ((proto_q == PROTO_TCP) && (idx_q == h12)) begin
            tw_d = data_byte_i[7:4];
          end
          if (in_sig && (sig_q == {1'b0, k}) && (data_byte_i == http_sig_byte(k))) begin
            sig_d = {1'b0, k} + 3'd1;
          end
        end
      end
    end

    len   = in_range ? (idx_q + IdxW'(1)) : IdxMax;
    hr    = IdxW'(hdr_bytes(ihl_d));
    hr4   = hr + IdxW'(4);
    hl    = hr + IdxW'(l4_bytes(proto_d, tw_d));
    l4_ok = (proto_d == PROTO_TCP) || (proto_d == PROTO_UDP);

    sum_o.src_ip      = src_d;
    sum_o.dst_addr    = dst_d;
    sum_o.ip_proto    = proto_d;
    sum_o.l4_ok       = l4_ok;
    sum_o.has_ports   = l4_ok && (len >= hr4);
    sum_o.src_port    = sum_o.has_ports ? sport_d : '0;
    sum_o.dst_port    = sum_o.has_ports ? dport_d : '0;
    sum_o.payload_len = (len >= hl) ? 16'(len - hl) : '0;
    sum_o.sig_hit     = sig_d == {1'b0, SIG_LEN[1:0] + 2'd0} + 3'd4 - 3'd0 - {1'b0, 2'd0};
    sum_o.truncated   = len < hl;
  end

  assign emit_o = last_byte_i && (ver_d == IP_VERSION_4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      ver_q   <= '0;
      ihl_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      sport_q <= '0;
      dport_q <= '0;
      tw_q    <= '0;
      sig_q   <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        idx_q   <= '0;
        ver_q   <= '0;
        ihl_q   <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        sport_q <= '0;
        dport_q <= '0;
        tw_q    <= '0;
        sig_q   <= '0;
      end else begin
        if (in_range) begin
          idx_q <= idx_q + IdxW'(1);
        end
        ver_q   <= ver_d;
        ihl_q   <= ihl_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        sport_q <= sport_d;
        dport_q <= dport_d;
        tw_q    <= tw_d;
        sig_q   <= sig_d;
      end
    end
  end

endmodule

// ===== rtl/ipv4_l4_port_classifier.sv =====
// Channel  Port   Dir  Payload
// in_i     sink   in   data_byte[7:0], last_byte
// out_o    source out  src_ip, dst_addr, ip_proto, has_ports, src_port, dst_port,
//                      payload_len, service, truncated
//
// One byte per cycle sustained unless a held result stalls a last byte; a byte is held in
// the input register, and its result, if any, shows on out_o the cycle after it leaves.
// Throughput is set by the single header capture stage: one byte a cycle unless stalled.
// Reset clears the parse state and both valid flags; no clearing pass.
// A held result stalls only a last byte of an IPv4 packet; other bytes keep flowing.
module ipv4_l4_port_classifier
  import ipl4c_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ipl4c_in_if.sink    in_i,
  ipl4c_out_if.source out_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  logic       emit;
  logic       adv;
  logic       out_free;
  pkt_sum_t   sum;

  logic        out_valid_q;
  logic [31:0] src_ip_q;
  logic [31:0] dst_addr_q;
  logic [7:0]  ip_proto_q;
  logic        has_ports_q;
  logic [15:0] src_port_q;
  logic [15:0] dst_port_q;
  logic [15:0] payload_len_q;
  svc_e        service_q;
  logic        truncated_q;

  ipl4c_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .emit_o      (emit),
    .sum_o       (sum)
  );

  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = in_valid_q && (!emit || out_free);
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      src_ip_q      <= sum.src_ip;
      dst_addr_q    <= sum.dst_addr;
      ip_proto_q    <= sum.ip_proto;
      has_ports_q   <= sum.has_ports;
      src_port_q    <= sum.src_port;
      dst_port_q    <= sum.dst_port;
      payload_len_q <= sum.payload_len;
      service_q     <= classify(sum.l4_ok, sum.src_port, sum.dst_port, sum.sig_hit);
      truncated_q   <= sum.truncated;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.src_ip      = src_ip_q;
  assign out_o.dst_addr    = dst_addr_q;
  assign out_o.ip_proto    = ip_proto_q;
  assign out_o.has_ports   = has_ports_q;
  assign out_o.src_port    = src_port_q;
  assign out_o.dst_port    = dst_port_q;
  assign out_o.payload_len = payload_len_q;
  assign out_o.service     = service_q;
  assign out_o.truncated   = truncated_q;

`ifndef SYNTHESIS
  a_none_no_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (service_q == SVC_NONE) |-> !has_ports_q)
    else $error("service none with ports");

  a_ports_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !has_ports_q |-> (src_port_q == '0) && (dst_port_q == '0))
    else $error("ports set without has_ports");

  a_trunc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && truncated_q |-> (payload_len_q == '0))
    else $error("truncated packet with payload");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit |=> out_valid_q)
    else $error("result lost");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(byte_q) && $stable(last_q))
    else $error("input register overwritten");
`endif

endmodule

// ===== verif/tb_ipv4_l4_port_classifier.sv =====
`timescale 1ns / 1ps

module tb_ipv4_l4_port_classifier;
  import ipl4c_pkg::*;

  localparam int unsigned MAX_PKT_BYTES  = 65535;
  localparam int unsigned RAND_BYTES     = 100;
  localparam int unsigned RAND_MIN_FLOWS = 2;
  localparam logic [31:0] HTTP_TAG       = 32'h4854_5450;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_CHOKE
  } sink_mode_e;

  typedef struct packed {
    logic [15:0] idx;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [3:0]  doff;
    logic [2:0]  sig;
  } parse_state_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_addr;
    logic [7:0]  ip_proto;
    logic        has_ports;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
    svc_e        service;
    logic        truncated;
  } flow_rec_t;

  typedef struct packed {
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  doff;
    int          pay;
    bit          http;
    int          cut;
  } pkt_spec_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ipl4c_in_if  in_if ();
  ipl4c_out_if out_if ();

  ipv4_l4_port_classifier #(
    .MAX_PACKET_BYTES(MAX_PKT_BYTES)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  parse_state_t ps;
  flow_rec_t    flow_q[$];
  flow_rec_t    exp_flow;
  logic [7:0]   pkt_bytes[$];
  int unsigned  err_cnt;
  int unsigned  flow_cnt;
  int unsigned  byte_cnt;
  int unsigned  burst_left;
  sink_mode_e   sink_mode;
  int unsigned  sink_left;
  logic [31:0]  sink_pat;

  always #10 clk_i = ~clk_i;

  function automatic int unsigned ihl_bytes(input logic [3:0] w);
    return (w < 4'd5) ? 20 : 4 * w;
  endfunction

  function automatic int unsigned l4_hdr_len(input logic [7:0] proto, input logic [3:0] doff);
    if (proto == PROTO_TCP) begin
      return ihl_bytes(doff);
    end
    return (proto == PROTO_UDP) ? 8 : 0;
  endfunction

  function automatic svc_e port_service(input logic [15:0] p);
    case (p)
      PORT_HTTP:     return SVC_HTTP;
      PORT_HTTPS:    return SVC_HTTPS;
      PORT_FTP_CTRL: return SVC_FTP_CTRL;
      PORT_FTP_DATA: return SVC_FTP_DATA;
      PORT_SMTP:     return SVC_SMTP;
      PORT_DNS:      return SVC_DNS;
      PORT_SSH:      return SVC_SSH;
      default:       return SVC_UNKNOWN;
    endcase
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic l);
    int unsigned idx;
    int unsigned h;
    int unsigned p;
    int unsigned len;
    int unsigned hl;
    logic        l4ok;
    svc_e        s;
    flow_rec_t   r;
    idx = ps.idx;
    if (idx < MAX_PKT_BYTES) begin
      if (idx == 0) begin
        ps.ver = b[7:4];
        ps.ihl = b[3:0];
      end else begin
        if (idx == 9) ps.proto = b;
        if (idx >= 12 && idx < 16) ps.sa = {ps.sa[23:0], b};
        if (idx >= 16 && idx < 20) ps.da = {ps.da[23:0], b};
        if (ps.proto == PROTO_TCP || ps.proto == PROTO_UDP) begin
          h = ihl_bytes(ps.ihl);
          if (idx == h || idx == h + 1) ps.sp = {ps.sp[7:0], b};
          if (idx == h + 2 || idx == h + 3) ps.dp = {ps.dp[7:0], b};
          if (ps.proto == PROTO_TCP && idx == h + 12) ps.doff = b[7:4];
          p = h + l4_hdr_len(ps.proto, ps.doff);
          if (idx >= p && idx < p + 4 && ps.sig == idx - p &&
              b == HTTP_TAG[31 - 8 * (idx - p) -: 8]) begin
            ps.sig = ps.sig + 3'd1;
          end
        end
      end
    end
    if (!l) begin
      if (idx < MAX_PKT_BYTES) ps.idx = idx + 1;
    end else begin
      if (ps.ver == IP_VERSION_4) begin
        len = (idx < MAX_PKT_BYTES) ? idx + 1 : MAX_PKT_BYTES;
        h = ihl_bytes(ps.ihl);
        hl = h + l4_hdr_len(ps.proto, ps.doff);
        l4ok = (ps.proto == PROTO_TCP) || (ps.proto == PROTO_UDP);
        r.src_ip      = ps.sa;
        r.dst_addr    = ps.da;
        r.ip_proto    = ps.proto;
        r.has_ports   = l4ok && (len >= h + 4);
        r.src_port    = r.has_ports ? ps.sp : 16'd0;
        r.dst_port    = r.has_ports ? ps.dp : 16'd0;
        r.payload_len = (len >= hl) ? len - hl : 0;
        r.truncated   = (len < hl);
        s = SVC_NONE;
        if (l4ok) begin
          s = (ps.sig == SIG_LEN) ? SVC_HTTP : SVC_UNKNOWN;
          if (port_service(r.src_port) < s) s = port_service(r.src_port);
          if (port_service(r.dst_port) < s) s = port_service(r.dst_port);
        end
        r.service = s;
        flow_q.push_back(r);
        flow_cnt++;
      end
      ps = '0;
    end
  endtask

  function automatic int unsigned next_gap();
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 48);
    return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    track_byte(b, l);
    byte_cnt++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
  endtask

  task automatic build_packet(input pkt_spec_t pk);
    int unsigned h;
    int unsigned l4;
    logic [7:0]  b;
    pkt_bytes.delete();
    h = ihl_bytes(pk.ihl);
    for (int i = 0; i < h; i++) begin
      b = $urandom;
      if (i == 0) b = {pk.ver, pk.ihl};
      if (i == 9) b = pk.proto;
      if (i >= 12 && i < 16) b = pk.sa[8 * (15 - i) +: 8];
      if (i >= 16 && i < 20) b = pk.da[8 * (19 - i) +: 8];
      pkt_bytes.push_back(b);
    end
    l4 = l4_hdr_len(pk.proto, pk.doff);
    for (int i = 0; i < l4; i++) begin
      b = $urandom;
      if (i < 2) b = pk.sport[8 * (1 - i) +: 8];
      if (i >= 2 && i < 4) b = pk.dport[8 * (3 - i) +: 8];
      if (i == 12) b = {pk.doff, b[3:0]};
      pkt_bytes.push_back(b);
    end
    for (int i = 0; i < pk.pay; i++) begin
      b = $urandom;
      if (i < 4 && (pk.http || $urandom_range(0, 2) == 0)) b = HTTP_TAG[31 - 8 * i -: 8];
      pkt_bytes.push_back(b);
    end
    if (pk.cut != 0) begin
      while (pkt_bytes.size() > pk.cut) pkt_bytes.pop_back();
    end
  endtask

  task automatic send_spec(input pkt_spec_t pk);
    build_packet(pk);
    send_packet();
  endtask

  function automatic pkt_spec_t base_spec(input logic [7:0] proto, input logic [15:0] sport,
                                          input logic [15:0] dport);
    pkt_spec_t pk;
    pk.ver   = IP_VERSION_4;
    pk.ihl   = MIN_HDR_WORDS;
    pk.proto = proto;
    pk.sa    = $urandom;
    pk.da    = $urandom;
    pk.sport = sport;
    pk.dport = dport;
    pk.doff  = MIN_HDR_WORDS;
    pk.pay   = 4;
    pk.http  = 1'b0;
    pk.cut   = 0;
    return pk;
  endfunction

  function automatic logic [15:0] pick_port();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      case ($urandom_range(0, 6))
        0:       return PORT_HTTP;
        1:       return PORT_HTTPS;
        2:       return PORT_FTP_CTRL;
        3:       return PORT_FTP_DATA;
        4:       return PORT_SMTP;
        5:       return PORT_DNS;
        default: return PORT_SSH;
      endcase
    end
    if (r == 4) return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    return $urandom;
  endfunction

  function automatic pkt_spec_t rand_spec();
    pkt_spec_t   pk;
    int unsigned r;
    pk = base_spec(PROTO_TCP, pick_port(), pick_port());
    if ($urandom_range(0, 9) == 0) pk.ver = $urandom;
    case ($urandom_range(0, 9))
      0:       pk.ihl = $urandom;
      1:       pk.ihl = $urandom_range(6, 9);
      default: pk.ihl = MIN_HDR_WORDS;
    endcase
    r = $urandom_range(0, 9);
    if (r >= 8) pk.proto = $urandom;
    else if (r >= 4) pk.proto = PROTO_UDP;
    if ($urandom_range(0, 6) == 0) pk.doff = $urandom;
    pk.pay  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
    pk.http = ($urandom_range(0, 4) == 0);
    pk.cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 48) : 0;
    return pk;
  endfunction

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (flow_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_service_ports();
    send_spec(base_spec(PROTO_TCP, PORT_HTTP, 16'd40000));
    send_spec(base_spec(PROTO_UDP, 16'd5000, PORT_HTTPS));
    send_spec(base_spec(PROTO_TCP, PORT_FTP_CTRL, 16'd1025));
    send_spec(base_spec(PROTO_UDP, 16'd3000, PORT_FTP_DATA));
    send_spec(base_spec(PROTO_TCP, 16'd61000, PORT_SMTP));
    send_spec(base_spec(PROTO_UDP, PORT_DNS, 16'd33333));
    send_spec(base_spec(PROTO_TCP, PORT_SSH, 16'd2222));
    send_spec(base_spec(PROTO_UDP, 16'd1234, 16'd5678));
    send_spec(base_spec(PROTO_TCP, PORT_SSH, PORT_HTTPS));
    send_spec(base_spec(PROTO_UDP, PORT_HTTPS, PORT_HTTP));
    wait_drained();
  endtask

  task automatic test_http_signature();
    pkt_spec_t pk;
    pk = base_spec(PROTO_TCP, 16'd4000, PORT_SSH);
    pk.http = 1'b1;
    send_spec(pk);
    pk.proto = PROTO_UDP;
    send_spec(pk);
    pk.proto = PROTO_TCP;
    pk.pay = 3;
    send_spec(pk);
    pk.pay = 6;
    pk.doff = 4'd8;
    send_spec(pk);
    wait_drained();
  endtask

  task automatic test_header_lengths();
    pkt_spec_t pk;
    pk = base_spec(PROTO_TCP, 16'd7000, 16'd7001);
    pk.ihl = 4'd0;
    send_spec(pk);
    pk = base_spec(PROTO_UDP, 16'd7002, PORT_DNS);
    pk.ihl = 4'd15;
    send_spec(pk);
    pk = base_spec(PROTO_TCP, 16'd7003, 16'd7004);
    pk.doff = 4'd2;
    pk.http = 1'b1;
    send_spec(pk);
    pk.doff = 4'd15;
    pk.pay = 4;
    send_spec(pk);
    send_spec(base_spec(8'd1, PORT_HTTP, PORT_HTTP));
    wait_drained();
  endtask

  task automatic test_truncation();
    pkt_spec_t pk;
    pk = base_spec(PROTO_TCP, PORT_HTTPS, 16'd9000);
    pk.cut = 1;
    send_spec(pk);
    pk.cut = 10;
    send_spec(pk);
    pk.cut = 22;
    send_spec(pk);
    pk.cut = 30;
    send_spec(pk);
    pk = base_spec(PROTO_UDP, PORT_SMTP, 16'd9001);
    pk.cut = 24;
    send_spec(pk);
    pk.pay = 0;
    pk.cut = 0;
    send_spec(pk);
    wait_drained();
  endtask

  task automatic test_non_ipv4();
    pkt_spec_t pk;
    pk = base_spec(PROTO_TCP, PORT_HTTP, 16'd8080);
    pk.ver = 4'd6;
    send_spec(pk);
    pk.ver = 4'd0;
    pk.cut = 1;
    send_spec(pk);
    pk.ver = 4'd15;
    pk.cut = 0;
    send_spec(pk);
    send_spec(base_spec(PROTO_UDP, PORT_DNS, PORT_DNS));
    wait_drained();
  endtask

  task automatic test_field_extremes();
    pkt_spec_t pk;
    pk = base_spec(PROTO_TCP, 16'h0000, 16'hffff);
    pk.sa = 32'h0000_0000;
    pk.da = 32'hffff_ffff;
    send_spec(pk);
    pk = base_spec(PROTO_UDP, 16'hffff, 16'h0000);
    pk.sa = 32'hffff_ffff;
    pk.da = 32'h0000_0000;
    send_spec(pk);
    pk.proto = 8'hff;
    send_spec(pk);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned start_bytes;
    int unsigned start_flows;
    start_bytes = byte_cnt;
    start_flows = flow_cnt;
    while (byte_cnt - start_bytes < RAND_BYTES || flow_cnt - start_flows < RAND_MIN_FLOWS) begin
      if ($urandom_range(0, 19) == 0) begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 30)) pkt_bytes.push_back($urandom);
        send_packet();
      end else begin
        send_spec(rand_spec());
      end
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (flow_q.size() == 0) begin
        $display("%0t: result with nothing expected, src 0x%0h dst 0x%0h", $time,
                 out_if.src_ip, out_if.dst_addr);
        err_cnt++;
      end else begin
        exp_flow = flow_q.pop_front();
        check_field("src_ip", exp_flow.src_ip, out_if.src_ip);
        check_field("dst_addr", exp_flow.dst_addr, out_if.dst_addr);
        check_field("ip_proto", exp_flow.ip_proto, out_if.ip_proto);
        check_field("has_ports", exp_flow.has_ports, out_if.has_ports);
        check_field("src_port", exp_flow.src_port, out_if.src_port);
        check_field("dst_port", exp_flow.dst_port, out_if.dst_port);
        check_field("payload_len", exp_flow.payload_len, out_if.payload_len);
        check_field("service", exp_flow.service, out_if.service);
        check_field("truncated", exp_flow.truncated, out_if.truncated);
      end
    end
  end

  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(16, 160);
      sink_pat  = $urandom;
    end
    sink_left--;
    case (sink_mode)
      SINK_OPEN:    out_if.ready <= 1'b1;
      SINK_RANDOM:  out_if.ready <= ($urandom_range(0, 3) != 0);
      SINK_PATTERN: out_if.ready <= sink_pat[sink_left % 32];
      default:      out_if.ready <= (sink_left % 24) < 4;
    endcase
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    ps              = '0;
    err_cnt         = 0;
    flow_cnt        = 0;
    byte_cnt        = 0;
    burst_left      = 0;
    sink_left       = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_service_ports();
    test_http_signature();
    test_header_lengths();
    test_truncation();
    test_non_ipv4();
    test_field_extremes();
    test_random_traffic();

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    for (int i = 0; i < 100000 && flow_q.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (flow_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, flow_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("[ipv4_l4_port_classifier] OK");
    end else begin
      $display("[ipv4_l4_port_classifier] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[ipv4_l4_port_classifier] ERROR");
    $finish;
  end

endmodule
